>>> hw/rtl/gtra_pkg.sv
// ============================================================================
// GEMM tile accumulator package
// Shared types, function codes and helpers for the rank-1 tile accumulator.
// ============================================================================
package gtra_pkg;

    localparam int LANES = 8;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_ACC   = 2'd1;
    localparam logic [1:0] FUNC_DRAIN = 2'd2;

    localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
    localparam logic [31:0] INF32  = 32'h7F80_0000;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ACC,
        OP_DRAIN
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DRD,
        ST_DOUT
    } t_state;

    typedef logic [LANES-1:0][31:0] t_row;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [31:0] alpha;
        logic [31:0] lane0;
        logic [31:0] lane1;
        logic [31:0] lane2;
        logic [31:0] lane3;
        logic [31:0] lane4;
        logic [31:0] lane5;
        logic [31:0] lane6;
        logic [31:0] lane7;
    } t_req;

    typedef struct packed {
        logic [3:0]  out_row;
        logic [31:0] sum0;
        logic [31:0] sum1;
        logic [31:0] sum2;
        logic [31:0] sum3;
        logic [31:0] sum4;
        logic [31:0] sum5;
        logic [31:0] sum6;
        logic [31:0] sum7;
        logic        last_row;
    } t_res;

    typedef struct packed {
        t_op         op;
        logic [3:0]  row;
        logic [31:0] alpha;
        t_row        lanes;
    } t_cmd;

    // Number of leading zeros of a 64-bit word; 64 for a zero word.
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n     = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/gtra_if.sv
// ============================================================================
// GEMM tile accumulator channels
// Valid/ready channels for requests into the block and rows out of it.
// ============================================================================
interface gtra_req_if;
    import gtra_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gtra_res_if;
    import gtra_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/gemm_tile_rank1_accumulator_core.sv
// ============================================================================
// GEMM tile rank-1 accumulator
// Top level: request queue front end and tile update back end.
// ============================================================================
// The block keeps a TILE_ROWS x TILE_COLS tile of binary32 accumulators. A
// load request writes its row straight into the tile. An accumulate request
// reads the tile row, passes it through eight five-stage fused multiply-add
// lanes and writes it back before the next request starts. A drain request
// streams the rows in turn, each through a registered tile read, and waits
// while the result side stalls. A two-entry queue lets requests be
// taken while an update or drain is in progress.
module gemm_tile_rank1_accumulator_core #(
    parameter int TILE_ROWS = 12,
    parameter int TILE_COLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gtra_req_if.sink    i_req,
    gtra_res_if.source  o_res
);
    import gtra_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    gtra_front #(
        .TILE_ROWS (TILE_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    gtra_back #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res       (o_res)
    );

endmodule

>>> hw/rtl/gtra_front.sv
// ============================================================================
// GEMM tile accumulator front end
// Accepts requests, drops the ones that do nothing, and queues the rest.
// ============================================================================
module gtra_front #(
    parameter int TILE_ROWS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gtra_req_if.sink          i_req,
    output logic              o_cmd_valid,
    output gtra_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import gtra_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       keep;
    logic       push;
    t_cmd       cls;

    always_comb begin
        cls.row   = i_req.data.row;
        cls.alpha = i_req.data.alpha;
        cls.lanes[0] = i_req.data.lane0;
        cls.lanes[1] = i_req.data.lane1;
        cls.lanes[2] = i_req.data.lane2;
        cls.lanes[3] = i_req.data.lane3;
        cls.lanes[4] = i_req.data.lane4;
        cls.lanes[5] = i_req.data.lane5;
        cls.lanes[6] = i_req.data.lane6;
        cls.lanes[7] = i_req.data.lane7;
        unique case (i_req.data.func)
            FUNC_LOAD: begin
                cls.op = OP_LOAD;
                keep   = 32'(i_req.data.row) < TILE_ROWS;
            end
            FUNC_ACC: begin
                cls.op = OP_ACC;
                keep   = 32'(i_req.data.row) < TILE_ROWS;
            end
            FUNC_DRAIN: begin
                cls.op = OP_DRAIN;
                keep   = 1'b1;
            end
            default: begin
                cls.op = OP_DRAIN;
                keep   = 1'b0;
            end
        endcase
    end

    assign i_req.ready = r_cnt != 2'(QDEPTH);
    assign push        = i_req.valid && i_req.ready && keep;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> hw/rtl/gtra_fma.sv
// ============================================================================
// GEMM tile accumulator fused multiply-add lane
// Five-stage binary32 a * b + c with a single round to nearest even.
// ============================================================================
module gtra_fma (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic        o_valid,
    output logic [31:0] o_result
);
    import gtra_pkg::*;

    logic [4:0] r_v;

    logic               r1_spec;
    logic [31:0]        r1_sval;
    logic [47:0]        r1_prod;
    logic signed [11:0] r1_ex0;
    logic [23:0]        r1_mc;
    logic signed [11:0] r1_ey0;
    logic               r1_zc;
    logic               r1_sp;
    logic               r1_sc;

    logic               r2_spec;
    logic [31:0]        r2_sval;
    logic [63:0]        r2_x;
    logic signed [11:0] r2_ex;
    logic [63:0]        r2_y;
    logic signed [11:0] r2_ey;
    logic               r2_zc;
    logic               r2_sp;
    logic               r2_sc;

    logic               r3_spec;
    logic [31:0]        r3_sval;
    logic [63:0]        r3_r;
    logic signed [11:0] r3_e;
    logic               r3_s;
    logic               r3_rz;

    logic               r4_spec;
    logic [31:0]        r4_sval;
    logic [63:0]        r4_r;
    logic signed [11:0] r4_e;
    logic signed [11:0] r4_sh;
    logic               r4_s;
    logic               r4_rz;

    logic [31:0]        r5_res;

    logic               s1_spec;
    logic [31:0]        s1_sval;
    logic [47:0]        s1_prod;
    logic signed [11:0] s1_ex0;
    logic [23:0]        s1_mc;
    logic signed [11:0] s1_ey0;

    logic [63:0]        s2_x;
    logic signed [11:0] s2_ex;
    logic [63:0]        s2_y;
    logic signed [11:0] s2_ey;

    logic [63:0]        s3_r;
    logic signed [11:0] s3_e;
    logic               s3_s;

    logic signed [11:0] s4_sh;
    logic [31:0]        s5_res;

    always_comb begin
        logic       sa, sb, sc, sp;
        logic [7:0] ea, eb, ec, xa, xb, xc;
        logic [22:0] fa, fb, fc;
        logic       za, zb, zc;
        logic [23:0] ma, mb;
        sa = i_a[31];
        sb = i_b[31];
        sc = i_c[31];
        sp = sa ^ sb;
        ea = i_a[30:23];
        eb = i_b[30:23];
        ec = i_c[30:23];
        fa = i_a[22:0];
        fb = i_b[22:0];
        fc = i_c[22:0];
        za = i_a[30:0] == 31'd0;
        zb = i_b[30:0] == 31'd0;
        zc = i_c[30:0] == 31'd0;
        xa = (ea != 8'd0) ? ea : 8'd1;
        xb = (eb != 8'd0) ? eb : 8'd1;
        xc = (ec != 8'd0) ? ec : 8'd1;
        ma = {ea != 8'd0, fa};
        mb = {eb != 8'd0, fb};
        s1_mc   = {ec != 8'd0, fc};
        s1_prod = 48'(ma) * 48'(mb);
        s1_ex0  = $signed({4'b0, xa}) + $signed({4'b0, xb}) - 12'sd300;
        s1_ey0  = $signed({4'b0, xc}) - 12'sd150;
        s1_spec = 1'b1;
        s1_sval = 32'd0;
        if ((ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0)
            || (ec == 8'hFF && fc != 23'd0)) begin
            s1_sval = QNAN32;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            if (za || zb || (ec == 8'hFF && sc != sp)) begin
                s1_sval = QNAN32;
            end else begin
                s1_sval = {sp, INF32[30:0]};
            end
        end else if (ec == 8'hFF) begin
            s1_sval = i_c;
        end else if (za || zb) begin
            s1_sval = zc ? {sp & sc, 31'd0} : i_c;
        end else begin
            s1_spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spec <= s1_spec;
        r1_sval <= s1_sval;
        r1_prod <= s1_prod;
        r1_ex0  <= s1_ex0;
        r1_mc   <= s1_mc;
        r1_ey0  <= s1_ey0;
        r1_zc   <= i_c[30:0] == 31'd0;
        r1_sp   <= i_a[31] ^ i_b[31];
        r1_sc   <= i_c[31];
    end

    always_comb begin
        logic [6:0]  lzp;
        logic [6:0]  lzy;
        logic [47:0] pn;
        logic [23:0] yn;
        lzp   = lzc64({r1_prod, 16'h0});
        lzy   = lzc64({r1_mc, 40'h0});
        pn    = r1_prod << lzp[5:0];
        yn    = r1_mc << lzy[5:0];
        s2_x  = {2'b0, pn, 14'b0};
        s2_y  = {2'b0, yn, 38'b0};
        s2_ex = r1_ex0 - 12'sd14 - $signed({5'b0, lzp});
        s2_ey = r1_ey0 - 12'sd38 - $signed({5'b0, lzy});
    end

    always_ff @(posedge i_clk) begin
        r2_spec <= r1_spec;
        r2_sval <= r1_sval;
        r2_x    <= s2_x;
        r2_ex   <= s2_ex;
        r2_y    <= s2_y;
        r2_ey   <= s2_ey;
        r2_zc   <= r1_zc;
        r2_sp   <= r1_sp;
        r2_sc   <= r1_sc;
    end

    always_comb begin
        logic [63:0]        big;
        logic [63:0]        sml;
        logic [63:0]        shd;
        logic signed [11:0] d;
        logic               sbig;
        logic               ssml;
        if (r2_ex >= r2_ey) begin
            big  = r2_x;
            sml  = r2_y;
            d    = r2_ex - r2_ey;
            s3_e = r2_ex;
            sbig = r2_sp;
            ssml = r2_sc;
        end else begin
            big  = r2_y;
            sml  = r2_x;
            d    = r2_ey - r2_ex;
            s3_e = r2_ey;
            sbig = r2_sc;
            ssml = r2_sp;
        end
        shd = sml >> d[5:0];
        if (d >= 12'sd63) begin
            sml = 64'd1;
        end else if (d > 12'sd0) begin
            sml = shd | 64'((shd << d[5:0]) != sml);
        end
        if (sbig == ssml) begin
            s3_r = big + sml;
            s3_s = sbig;
        end else if (big >= sml) begin
            s3_r = big - sml;
            s3_s = sbig;
        end else begin
            s3_r = sml - big;
            s3_s = ssml;
        end
        if (r2_zc) begin
            s3_r = r2_x;
            s3_e = r2_ex;
            s3_s = r2_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_spec <= r2_spec;
        r3_sval <= r2_sval;
        r3_r    <= s3_r;
        r3_e    <= s3_e;
        r3_s    <= s3_s;
        r3_rz   <= !r2_zc && s3_r == 64'd0;
    end

    always_comb begin
        logic [6:0]         lz;
        logic signed [11:0] lim;
        lz    = lzc64(r3_r);
        s4_sh = 12'sd40 - $signed({5'b0, lz});
        lim   = -12'sd149 - r3_e;
        if (lim > s4_sh) begin
            s4_sh = lim;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_spec <= r3_spec;
        r4_sval <= r3_sval;
        r4_r    <= r3_r;
        r4_e    <= r3_e;
        r4_sh   <= s4_sh;
        r4_s    <= r3_s;
        r4_rz   <= r3_rz;
    end

    always_comb begin
        logic [63:0]        m;
        logic [63:0]        rem;
        logic [63:0]        half;
        logic [63:0]        val;
        logic [5:0]         amt;
        logic signed [11:0] nsh;
        logic signed [11:0] bem1;
        amt  = r4_sh[5:0];
        nsh  = -r4_sh;
        rem  = r4_r & ((64'd1 << amt) - 64'd1);
        half = 64'd1 << (amt - 6'd1);
        if (r4_sh > 12'sd0) begin
            m = r4_r >> amt;
            if (rem > half || (rem == half && m[0])) begin
                m = m + 64'd1;
            end
        end else begin
            m = r4_r << nsh[5:0];
        end
        bem1 = r4_e + r4_sh + 12'sd149;
        val  = ({52'b0, bem1} << 23) + m;
        if (r4_spec) begin
            s5_res = r4_sval;
        end else if (r4_rz) begin
            s5_res = 32'd0;
        end else if (r4_sh >= 12'sd64) begin
            s5_res = {r4_s, 31'd0};
        end else if (val >= 64'(INF32)) begin
            s5_res = {r4_s, INF32[30:0]};
        end else begin
            s5_res = {r4_s, val[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r5_res <= s5_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 5'd0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    assign o_valid  = r_v[4];
    assign o_result = r5_res;

endmodule

>>> hw/rtl/gtra_back.sv
// ============================================================================
// GEMM tile accumulator back end
// Holds the tile, runs row loads and rank-1 updates, and streams drains.
// ============================================================================
module gtra_back #(
    parameter int TILE_ROWS = 12,
    parameter int TILE_COLS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  gtra_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    gtra_res_if.source        o_res
);
    import gtra_pkg::*;

    localparam int RowW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

    t_row            r_mem [TILE_ROWS];
    t_row            r_rd_data;
    t_state          r_state;
    t_state          n_state;
    t_cmd            r_cmd;
    logic [RowW-1:0] r_row;
    logic [RowW-1:0] r_idx;
    logic            r_out_valid;
    t_res            r_out;

    logic [RowW+3:0] head_ext;
    logic [RowW-1:0] head_row;
    logic [RowW+3:0] idx_ext;
    logic            idx_last;
    logic            out_free;
    logic            rd_en;
    logic [RowW-1:0] rd_addr;
    logic            wr_en;
    logic [RowW-1:0] wr_addr;
    t_row            wr_data;
    logic            fma_go;
    logic            out_load;
    logic [LANES-1:0] fma_v;
    t_row            fma_res;

    function automatic t_row col_mask(input t_row v);
        t_row o;
        for (int j = 0; j < LANES; j++) begin
            o[j] = (j < TILE_COLS) ? v[j] : 32'd0;
        end
        return o;
    endfunction

    assign head_ext = {{RowW{1'b0}}, i_cmd.row};
    assign head_row = head_ext[RowW-1:0];
    assign idx_ext  = {4'b0, r_idx};
    assign idx_last = r_idx == RowW'(TILE_ROWS - 1);
    assign out_free = !r_out_valid || o_res.ready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        gtra_fma u_fma (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (fma_go),
            .i_a      (r_cmd.alpha),
            .i_b      (r_cmd.lanes[g]),
            .i_c      (r_rd_data[g]),
            .o_valid  (fma_v[g]),
            .o_result (fma_res[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_LOAD:  n_state = ST_IDLE;
                        OP_ACC:   n_state = ST_READ;
                        OP_DRAIN: n_state = ST_DRD;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: n_state = ST_CALC;
            ST_CALC: begin
                if (fma_v[0]) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRD:  n_state = ST_DOUT;
            ST_DOUT: begin
                if (out_free) begin
                    n_state = idx_last ? ST_IDLE : ST_DRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr_en     = 1'b0;
        wr_addr   = r_row;
        wr_data   = col_mask(fma_res);
        fma_go    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid && i_cmd.op == OP_ACC) begin
                    rd_en   = 1'b1;
                    rd_addr = head_row;
                end
                if (i_cmd_valid && i_cmd.op == OP_LOAD) begin
                    wr_en   = 1'b1;
                    wr_addr = head_row;
                    wr_data = col_mask(i_cmd.lanes);
                end
            end
            ST_READ: fma_go = 1'b1;
            ST_CALC: wr_en = fma_v[0];
            ST_DRD:  rd_en = 1'b1;
            ST_DOUT: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop && i_cmd.op == OP_DRAIN) begin
                r_idx <= '0;
            end else if (out_load) begin
                r_idx <= r_idx + RowW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_row <= head_row;
        end
        if (out_load) begin
            r_out.out_row  <= idx_ext[3:0];
            r_out.sum0     <= r_rd_data[0];
            r_out.sum1     <= r_rd_data[1];
            r_out.sum2     <= r_rd_data[2];
            r_out.sum3     <= r_rd_data[3];
            r_out.sum4     <= r_rd_data[4];
            r_out.sum5     <= r_rd_data[5];
            r_out.sum6     <= r_rd_data[6];
            r_out.sum7     <= r_rd_data[7];
            r_out.last_row <= idx_last;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef NO_ASSERTIONS
    a_fma_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fma_v[0] |-> r_state == ST_CALC)
        else $error("FMA result arrived outside the update state");
    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && idx_last) |=> r_state == ST_IDLE)
        else $error("Drain did not end after the last row");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (i_cmd_valid && r_state == ST_IDLE))
        else $error("Command popped while none was pending");
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("Tile memory read and written in one cycle");
`endif

endmodule
